### rtl/e2rgb_pkg.sv
// Shared types, constants and the color table lookup for the energy colormap.
package e2rgb_pkg;

  localparam int CHANNEL_BITS   = 8;
  localparam int ENTRY_BITS     = 3 * CHANNEL_BITS;
  localparam int PAIR_BITS      = 2 * ENTRY_BITS;
  localparam int NUM_PAIRS      = 5;
  localparam int NUM_ENTRIES    = 2 * NUM_PAIRS;
  localparam int ENERGY_BITS    = 32;
  localparam int FRAC_BITS      = 16;
  localparam int VAL_BITS       = FRAC_BITS + 1;
  localparam int SEG_BITS       = 3;
  localparam int IDX_BITS       = 4;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = PAIR_BITS;
  localparam int PAIR_SEL_BITS  = $clog2(NUM_PAIRS);

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_ENERGY_LOW  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_RECIP = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COLORS_FIRST = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COLORS_LAST  = 3'd6;

  localparam logic [IDX_BITS-1:0] LAST_ENTRY = 4'(NUM_ENTRIES - 1);

  typedef logic [NUM_PAIRS-1:0][PAIR_BITS-1:0] color_table_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] r;
    logic [CHANNEL_BITS-1:0] g;
    logic [CHANNEL_BITS-1:0] b;
  } rgb_t;

  // Scaled sample handed from the multiplier pipe to the interpolator
  typedef struct packed {
    logic                      bg;       // energy was exactly zero
    logic                      pos;      // product is strictly positive
    logic [2*ENERGY_BITS-1:0]  product;  // magnitude of offset * reciprocal
  } scaled_t;

  localparam logic signed [ENERGY_BITS-1:0] ENERGY_LOW_RESET  = 32'sd0;
  localparam logic signed [ENERGY_BITS-1:0] RANGE_RECIP_RESET = 32'sd65536;

  // Blue-cyan-green-yellow-red ramp, pair 0 in the low slot
  localparam color_table_t COLORS_RESET = {
    48'd280595380764672,
    48'd280920942706432,
    48'd140733193453312,
    48'd1097347432447,
    48'd549739036927
  };

  function automatic rgb_t entry_rgb(input color_table_t tbl, input logic [IDX_BITS-1:0] k);
    logic [IDX_BITS-1:0]      kk;
    logic [PAIR_SEL_BITS-1:0] pair;
    logic [ENTRY_BITS-1:0]    word;
    kk   = (k > LAST_ENTRY) ? LAST_ENTRY : k;
    pair = kk[IDX_BITS-1:1];
    word = kk[0] ? tbl[pair][PAIR_BITS-1:ENTRY_BITS] : tbl[pair][ENTRY_BITS-1:0];
    return rgb_t'(word);
  endfunction

endpackage

### rtl/energy_to_rgb_colormap_top.sv
// Energy colormap top level: configuration registers and the five-stage pixel pipeline.
// Each accepted energy item passes through all 5 register stages before its pixel is valid.
// Throughput: 1 item per cycle unless the output stalls; the 32x32 magnitude multiplier stage bounds the clock.
// Each stage advances when it is empty or its successor advances, so bubbles close up
// and a stalled pixel output holds while upstream stages keep filling.
// Reset (synchronous, rst high) empties the pipe and loads the default ramp and scale.
module energy_to_rgb_colormap_top (
  input  logic                                      clk,
  input  logic                                      rst,
  // configuration write port
  input  logic                                      cfg_write,
  input  logic [e2rgb_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [e2rgb_pkg::CFG_DATA_BITS-1:0]       cfg_data,
  // energy samples
  input  logic                                      sample_valid,
  output logic                                      sample_ready,
  input  logic signed [e2rgb_pkg::ENERGY_BITS-1:0]  energy,
  // pixels
  output logic                                      pixel_valid,
  input  logic                                      pixel_ready,
  output logic [e2rgb_pkg::CHANNEL_BITS-1:0]        red,
  output logic [e2rgb_pkg::CHANNEL_BITS-1:0]        green,
  output logic [e2rgb_pkg::CHANNEL_BITS-1:0]        blue
);
  import e2rgb_pkg::*;

  // Configuration registers; the user must write them only while the pipe is idle (not enforced here)
  logic signed [ENERGY_BITS-1:0] energy_low;
  logic signed [ENERGY_BITS-1:0] range_reciprocal;
  color_table_t                  colors;

  logic [CFG_INDEX_BITS-1:0]     pair_idx;

  // Handoff between the scaling pipe and the interpolator
  logic                          mid_valid;
  logic                          mid_ready;
  scaled_t                       mid_data;
  rgb_t                          pixel;

  assign pair_idx = cfg_index - REG_COLORS_FIRST;

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_low       <= ENERGY_LOW_RESET;
      range_reciprocal <= RANGE_RECIP_RESET;
      colors           <= COLORS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ENERGY_LOW:  energy_low       <= $signed(cfg_data[ENERGY_BITS-1:0]);
        REG_RANGE_RECIP: range_reciprocal <= $signed(cfg_data[ENERGY_BITS-1:0]);
        default: begin
          // color pairs; drop writes past the last register
          if (cfg_index >= REG_COLORS_FIRST && cfg_index <= REG_COLORS_LAST)
            colors[pair_idx[PAIR_SEL_BITS-1:0]] <= cfg_data;
        end
      endcase
    end
  end

  // Stages 1-3: offset from the low bound, sign split, magnitude product
  e2rgb_scale u_scale (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (sample_valid),
    .in_ready         (sample_ready),
    .energy           (energy),
    .energy_low       (energy_low),
    .range_reciprocal (range_reciprocal),
    .out_valid        (mid_valid),
    .out_ready        (mid_ready),
    .out_data         (mid_data)
  );

  // Stages 4-5: clamp, segment select, per-channel blend into the output register
  e2rgb_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (mid_data),
    .colors    (colors),
    .out_valid (pixel_valid),
    .out_ready (pixel_ready),
    .out_pixel (pixel)
  );

  assign red   = pixel.r;
  assign green = pixel.g;
  assign blue  = pixel.b;

endmodule

### rtl/e2rgb_scale.sv
// Three-stage pipe: energy offset, sign split, offset times reciprocal.
module e2rgb_scale (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic signed [e2rgb_pkg::ENERGY_BITS-1:0]      energy,
  input  logic signed [e2rgb_pkg::ENERGY_BITS-1:0]      energy_low,
  input  logic signed [e2rgb_pkg::ENERGY_BITS-1:0]      range_reciprocal,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output e2rgb_pkg::scaled_t                            out_data
);
  import e2rgb_pkg::*;

  // Stage 1: offset
  logic                          v1;
  logic                          bg1;
  logic signed [ENERGY_BITS:0]   offset1;
  // Stage 2: magnitudes
  logic                          v2;
  logic                          bg2;
  logic                          pos2;
  logic [ENERGY_BITS-1:0]        mag_off2;
  logic [ENERGY_BITS-1:0]        mag_rec2;
  // Stage 3: product
  logic                          v3;
  scaled_t                       s3;

  logic r1, r2, r3;
  logic [ENERGY_BITS:0]          neg_off;
  logic [ENERGY_BITS-1:0]        neg_rec;

  assign r3 = !v3 || out_ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  assign neg_off = -offset1;
  assign neg_rec = -range_reciprocal;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      bg1     <= (energy == '0);
      offset1 <= {energy[ENERGY_BITS-1], energy} -
                 {energy_low[ENERGY_BITS-1], energy_low};
    end
    if (r2) begin
      bg2      <= bg1;
      // positive only when both factors are nonzero and share a sign
      pos2     <= (offset1 != '0) && (range_reciprocal != '0) &&
                  (offset1[ENERGY_BITS] == range_reciprocal[ENERGY_BITS-1]);
      mag_off2 <= offset1[ENERGY_BITS] ? neg_off[ENERGY_BITS-1:0]
                                       : offset1[ENERGY_BITS-1:0];
      mag_rec2 <= range_reciprocal[ENERGY_BITS-1] ? neg_rec : range_reciprocal;
    end
    if (r3) begin
      s3.bg      <= bg2;
      s3.pos     <= pos2;
      s3.product <= mag_off2 * mag_rec2;
    end
  end

  assign out_valid = v3;
  assign out_data  = s3;

endmodule

### rtl/e2rgb_interp.sv
// Two-stage pipe: clamp and table fetch, then linear blend into the pixel register.
module e2rgb_interp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  e2rgb_pkg::scaled_t        in_data,
  input  e2rgb_pkg::color_table_t   colors,
  output logic                      out_valid,
  input  logic                      out_ready,
  output e2rgb_pkg::rgb_t           out_pixel
);
  import e2rgb_pkg::*;

  localparam int DIFF_BITS = CHANNEL_BITS + 1;
  localparam int NUM_BITS  = CHANNEL_BITS + FRAC_BITS + 2;

  logic                              v4;
  logic                              bg4;
  logic [FRAC_BITS-1:0]              weight4;
  rgb_t                              c0_4;
  logic signed [DIFF_BITS-1:0]       dr4, dg4, db4;

  logic                              v5;
  rgb_t                              pix5;

  logic r4, r5;
  logic [VAL_BITS-1:0]               val;
  logic [IDX_BITS-1:0]               idx;
  rgb_t                              c0, c1;

  assign r5 = !v5 || out_ready;
  assign r4 = !v4 || r5;
  assign in_ready = r4;

  // Clamp to 0..1 in Q1.16; anything at or above 2^32 saturates to one
  always_comb begin
    if (!in_data.pos) begin
      val = '0;
    end else if (in_data.product[2*ENERGY_BITS-1:ENERGY_BITS] != '0) begin
      val = {1'b1, {FRAC_BITS{1'b0}}};
    end else begin
      val = {1'b0, in_data.product[ENERGY_BITS-1:FRAC_BITS]};
    end
  end

  // Eight segments: integer part of 8*val picks the entry
  assign idx = val[VAL_BITS-1:FRAC_BITS-SEG_BITS];
  assign c0  = entry_rgb(colors, idx);
  assign c1  = entry_rgb(colors, idx + 4'd1);

  function automatic logic [CHANNEL_BITS-1:0] blend(
    input logic [CHANNEL_BITS-1:0]     base,
    input logic signed [DIFF_BITS-1:0] diff,
    input logic [FRAC_BITS-1:0]        w
  );
    logic signed [NUM_BITS-1:0] wide_w;
    logic signed [NUM_BITS-1:0] wide_d;
    logic signed [NUM_BITS-1:0] num;
    // Widen both factors first so the product keeps every bit
    wide_w = $signed(NUM_BITS'(w));
    wide_d = NUM_BITS'(diff);
    num = $signed({2'b00, base, {FRAC_BITS{1'b0}}}) + wide_w * wide_d;
    if (num[NUM_BITS-1])
      return '0;
    else if (num[NUM_BITS-2])
      return '1;
    else
      return num[FRAC_BITS+CHANNEL_BITS-1:FRAC_BITS];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r4) v4 <= in_valid;
      if (r5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (r4) begin
      bg4     <= in_data.bg;
      weight4 <= {val[FRAC_BITS-SEG_BITS-1:0], {SEG_BITS{1'b0}}};
      c0_4    <= c0;
      dr4     <= $signed({1'b0, c1.r}) - $signed({1'b0, c0.r});
      dg4     <= $signed({1'b0, c1.g}) - $signed({1'b0, c0.g});
      db4     <= $signed({1'b0, c1.b}) - $signed({1'b0, c0.b});
    end
    if (r5) begin
      if (bg4) begin
        pix5 <= '0;
      end else begin
        pix5.r <= blend(c0_4.r, dr4, weight4);
        pix5.g <= blend(c0_4.g, dg4, weight4);
        pix5.b <= blend(c0_4.b, db4, weight4);
      end
    end
  end

  assign out_valid = v5;
  assign out_pixel = pix5;

endmodule

### rtl/e2rgb_checker.sv
// Port-level checks for the energy colormap, bound to the top level.
module e2rgb_checker (
  input logic                                      clk,
  input logic                                      rst,
  input logic                                      sample_valid,
  input logic                                      sample_ready,
  input logic                                      pixel_valid,
  input logic                                      pixel_ready,
  input logic [e2rgb_pkg::CHANNEL_BITS-1:0]        red,
  input logic [e2rgb_pkg::CHANNEL_BITS-1:0]        green,
  input logic [e2rgb_pkg::CHANNEL_BITS-1:0]        blue
);

  // Reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) rst |=> !pixel_valid)
    else $error("pixel valid right after reset");

  // Input backpressure only when the whole pipe is full and the output stalls
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !sample_ready |-> (pixel_valid && !pixel_ready))
    else $error("sample ready low without an output stall");

  // Hold a stalled pixel
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_ready) |=> pixel_valid)
    else $error("pixel dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_ready) |=> ($stable(red) && $stable(green) && $stable(blue)))
    else $error("pixel changed while stalled");

endmodule

bind energy_to_rgb_colormap_top e2rgb_checker u_checker (.*);
